@@ src/svam_pkg.sv @@
// shared types, widths and codes for the sustained vital alarm manager
// used by every module of the block; depends on nothing
package svam_pkg;

  // timestamp width and fixed-point fraction of the vital values
  localparam int TIME_BITS       = 32;
  localparam int VALUE_FRAC_BITS = 4;

  // field widths
  localparam int STAMP_IN_W = 32;
  localparam int OX_W       = 11;
  localparam int HR_W       = 13;
  localparam int VENDOR_W   = 7;
  localparam int OWN_W      = 3;
  localparam int MASK_W     = VENDOR_W + OWN_W;
  localparam int NOTICE_W   = 2;

  // configuration register widths
  localparam int OX_LIM_W  = 7;
  localparam int HRL_LIM_W = 8;
  localparam int HRH_LIM_W = 9;
  localparam int HOLD_W    = 9;
  localparam int POLL_W    = 4;
  localparam int GAP_W     = POLL_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;

  // width that holds both a shifted limit and a raw value
  localparam int LIM_SH_W = HRH_LIM_W + VALUE_FRAC_BITS;
  localparam int CMP_W    = (HR_W > LIM_SH_W) ? HR_W : LIM_SH_W;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // own rule positions
  localparam int RULE_OX  = 0;
  localparam int RULE_HRL = 1;
  localparam int RULE_HRH = 2;

  // request codes
  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_ACK  = 1'b1;

  // battery notice codes
  localparam logic [NOTICE_W-1:0] NOTICE_NONE = 2'd0;
  localparam logic [NOTICE_W-1:0] NOTICE_LOW  = 2'd1;
  localparam logic [NOTICE_W-1:0] NOTICE_CRIT = 2'd2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ENABLE = 3'd0,
    CFG_OX_LIMIT   = 3'd1,
    CFG_OX_HOLD    = 3'd2,
    CFG_HRL_LIMIT  = 3'd3,
    CFG_HRL_HOLD   = 3'd4,
    CFG_HRH_LIMIT  = 3'd5,
    CFG_HRH_HOLD   = 3'd6,
    CFG_POLL       = 3'd7
  } cfg_reg_e;

  // register reset values
  localparam logic                 RST_OWN_ENABLE = 1'b0;
  localparam logic [OX_LIM_W-1:0]  RST_OX_LIMIT   = 7'd90;
  localparam logic [HOLD_W-1:0]    RST_HOLD       = 9'd10;
  localparam logic [HRL_LIM_W-1:0] RST_HRL_LIMIT  = 8'd80;
  localparam logic [HRH_LIM_W-1:0] RST_HRH_LIMIT  = 9'd200;
  localparam logic [POLL_W-1:0]    RST_POLL       = 4'd10;
  localparam logic [GAP_W-1:0]     GAP_SLACK      = 6'd5;

  // settings the back end needs
  typedef struct packed {
    logic              own_enable;
    logic [HOLD_W-1:0] ox_hold;
    logic [HOLD_W-1:0] hrl_hold;
    logic [HOLD_W-1:0] hrh_hold;
    logic [POLL_W-1:0] poll;
  } cfg_t;

  // one classified event
  typedef struct packed {
    logic                 req;
    logic                 new_sample;
    logic                 vitals_fresh;
    logic                 cloud_fresh;
    logic [TIME_BITS-1:0] stamp;
    logic [OWN_W-1:0]     holds;
    logic [VENDOR_W-1:0]  vendor;
    logic [NOTICE_W-1:0]  notice;
  } entry_t;

endpackage

@@ src/svam_front.sv @@
// front end: configuration registers, event intake and classification
// depends on svam_pkg
module svam_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [svam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [svam_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  // event channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic                              new_sample_i,
  input  logic                              vitals_fresh_i,
  input  logic                              cloud_fresh_i,
  input  logic [svam_pkg::STAMP_IN_W-1:0]   measured_time_i,
  input  logic [svam_pkg::OX_W-1:0]         oxygen_value_i,
  input  logic [svam_pkg::HR_W-1:0]         heart_value_i,
  input  logic [svam_pkg::VENDOR_W-1:0]     vendor_flags_i,
  input  logic                              battery_critical_i,
  input  logic                              battery_low_i,
  // queue side
  input  logic                              q_full_i,
  output logic                              push_o,
  output svam_pkg::entry_t                  entry_o,
  output svam_pkg::cfg_t                    cfg_o
);

  logic                              own_enable_q;
  logic [svam_pkg::OX_LIM_W-1:0]     ox_limit_q;
  logic [svam_pkg::HOLD_W-1:0]       ox_hold_q;
  logic [svam_pkg::HRL_LIM_W-1:0]    hrl_limit_q;
  logic [svam_pkg::HOLD_W-1:0]       hrl_hold_q;
  logic [svam_pkg::HRH_LIM_W-1:0]    hrh_limit_q;
  logic [svam_pkg::HOLD_W-1:0]       hrh_hold_q;
  logic [svam_pkg::POLL_W-1:0]       poll_q;

  logic [svam_pkg::CMP_W-1:0] ox_val, hr_val, ox_lim, hrl_lim, hrh_lim;

  // register file, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_enable_q <= svam_pkg::RST_OWN_ENABLE;
      ox_limit_q   <= svam_pkg::RST_OX_LIMIT;
      ox_hold_q    <= svam_pkg::RST_HOLD;
      hrl_limit_q  <= svam_pkg::RST_HRL_LIMIT;
      hrl_hold_q   <= svam_pkg::RST_HOLD;
      hrh_limit_q  <= svam_pkg::RST_HRH_LIMIT;
      hrh_hold_q   <= svam_pkg::RST_HOLD;
      poll_q       <= svam_pkg::RST_POLL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (svam_pkg::cfg_reg_e'(cfg_idx_i))
        svam_pkg::CFG_OWN_ENABLE: own_enable_q <= cfg_data_i[0];
        svam_pkg::CFG_OX_LIMIT:   ox_limit_q   <= cfg_data_i[svam_pkg::OX_LIM_W-1:0];
        svam_pkg::CFG_OX_HOLD:    ox_hold_q    <= cfg_data_i[svam_pkg::HOLD_W-1:0];
        svam_pkg::CFG_HRL_LIMIT:  hrl_limit_q  <= cfg_data_i[svam_pkg::HRL_LIM_W-1:0];
        svam_pkg::CFG_HRL_HOLD:   hrl_hold_q   <= cfg_data_i[svam_pkg::HOLD_W-1:0];
        svam_pkg::CFG_HRH_LIMIT:  hrh_limit_q  <= cfg_data_i[svam_pkg::HRH_LIM_W-1:0];
        svam_pkg::CFG_HRH_HOLD:   hrh_hold_q   <= cfg_data_i[svam_pkg::HOLD_W-1:0];
        svam_pkg::CFG_POLL:       poll_q       <= cfg_data_i[svam_pkg::POLL_W-1:0];
      endcase
    end
  end

  assign cfg_o.own_enable = own_enable_q;
  assign cfg_o.ox_hold    = ox_hold_q;
  assign cfg_o.hrl_hold   = hrl_hold_q;
  assign cfg_o.hrh_hold   = hrh_hold_q;
  assign cfg_o.poll       = poll_q;

  // limits scaled to the fixed-point grid of the values
  assign ox_val  = svam_pkg::CMP_W'(oxygen_value_i);
  assign hr_val  = svam_pkg::CMP_W'(heart_value_i);
  assign ox_lim  = svam_pkg::CMP_W'(ox_limit_q) << svam_pkg::VALUE_FRAC_BITS;
  assign hrl_lim = svam_pkg::CMP_W'(hrl_limit_q) << svam_pkg::VALUE_FRAC_BITS;
  assign hrh_lim = svam_pkg::CMP_W'(hrh_limit_q) << svam_pkg::VALUE_FRAC_BITS;

  // intake: take a word whenever the queue has room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the event
  always_comb begin
    entry_o.req          = req_type_i;
    entry_o.new_sample   = new_sample_i;
    entry_o.vitals_fresh = vitals_fresh_i;
    entry_o.cloud_fresh  = cloud_fresh_i;
    entry_o.stamp        = svam_pkg::TIME_BITS'(measured_time_i);
    entry_o.holds[svam_pkg::RULE_OX]  = ox_val < ox_lim;
    entry_o.holds[svam_pkg::RULE_HRL] = hr_val < hrl_lim;
    entry_o.holds[svam_pkg::RULE_HRH] = hr_val > hrh_lim;
    entry_o.vendor       = vendor_flags_i;
    priority if (!cloud_fresh_i) begin
      entry_o.notice = svam_pkg::NOTICE_NONE;
    end else if (battery_critical_i) begin
      entry_o.notice = svam_pkg::NOTICE_CRIT;
    end else if (battery_low_i) begin
      entry_o.notice = svam_pkg::NOTICE_LOW;
    end else begin
      entry_o.notice = svam_pkg::NOTICE_NONE;
    end
  end

endmodule

@@ src/svam_queue.sv @@
// short register queue between the front and back ends
// depends on svam_pkg
module svam_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  svam_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output svam_pkg::entry_t entry_o
);

  svam_pkg::entry_t             slot_q [svam_pkg::QUEUE_DEPTH];
  logic [svam_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [svam_pkg::QCNT_W-1:0]  count_q;

  assign full_o  = count_q == svam_pkg::QCNT_W'(svam_pkg::QUEUE_DEPTH);
  assign avail_o = count_q != '0;
  assign entry_o = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == svam_pkg::QPTR_W'(svam_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == svam_pkg::QPTR_W'(svam_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/svam_back.sv @@
// back end: sustained rule timing, alarm mask, ack and sound state, result register
// depends on svam_pkg
module svam_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  svam_pkg::cfg_t                   cfg_i,
  input  logic                             q_avail_i,
  input  svam_pkg::entry_t                 entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [svam_pkg::MASK_W-1:0]      alarm_bits_o,
  output logic                             unacked_alarm_o,
  output logic                             critical_o,
  output logic [svam_pkg::NOTICE_W-1:0]    battery_notice_o,
  output logic                             offline_last_known_o,
  output logic                             sound_request_o,
  output logic                             muted_o
);

  localparam int TB = svam_pkg::TIME_BITS;
  localparam int NR = svam_pkg::OWN_W;

  // rule and alarm state
  logic [TB-1:0]               start_q [NR];
  logic [TB-1:0]               start_d [NR];
  logic [NR-1:0]               flags_q, flags_d;
  logic [TB-1:0]               last_q, last_d;
  logic [svam_pkg::MASK_W-1:0] latched_q, latched_d, acked_q, acked_d;
  logic                        sound_q, sound_d, silenced_q, silenced_d;

  // result register
  logic                          out_valid_q;
  logic [svam_pkg::MASK_W-1:0]   alarm_q;
  logic                          unacked_q, critical_q, offline_q;
  logic [svam_pkg::NOTICE_W-1:0] notice_q;

  // step datapath
  logic [svam_pkg::HOLD_W-1:0] hold [NR];
  logic [TB-1:0]               elapsed [NR];
  logic [NR-1:0]               base_zero, fire, rule_flags;
  logic [TB-1:0]               last_gap;
  logic [svam_pkg::GAP_W-1:0]  gap;
  logic                        jump, run, wipe;
  logic [svam_pkg::MASK_W-1:0] mask, acked_new;

  assign hold[svam_pkg::RULE_OX]  = cfg_i.ox_hold;
  assign hold[svam_pkg::RULE_HRL] = cfg_i.hrl_hold;
  assign hold[svam_pkg::RULE_HRH] = cfg_i.hrh_hold;

  // take a word when the result slot is free or being emptied
  assign pop_o = q_avail_i && (!out_valid_q || !out_stall_i);

  // timestamp jump check, all three rules evaluated in parallel
  always_comb begin
    gap      = svam_pkg::GAP_W'({cfg_i.poll, 1'b0}) + svam_pkg::GAP_SLACK;
    last_gap = entry_i.stamp - last_q;
    jump     = (last_q != '0) &&
               ((entry_i.stamp < last_q) || (last_gap > TB'(gap)));
    for (int i = 0; i < NR; i++) begin
      elapsed[i]   = entry_i.stamp - start_q[i];
      base_zero[i] = jump || (start_q[i] == '0);
      fire[i]      = base_zero[i] ? (hold[i] == '0) : (elapsed[i] >= TB'(hold[i]));
      rule_flags[i] = entry_i.holds[i] && fire[i];
    end
  end

  // next state for one word
  always_comb begin
    wipe = !cfg_i.own_enable || !entry_i.vitals_fresh;
    run  = !wipe && entry_i.new_sample;
    for (int i = 0; i < NR; i++) begin
      start_d[i] = start_q[i];
    end
    flags_d    = flags_q;
    last_d     = last_q;
    latched_d  = latched_q;
    acked_d    = acked_q;
    sound_d    = sound_q;
    silenced_d = silenced_q;
    mask       = '0;
    acked_new  = '0;
    if (entry_i.req == svam_pkg::REQ_ACK) begin
      acked_d    = latched_q;
      silenced_d = latched_q != '0;
      sound_d    = 1'b0;
    end else begin
      // rule update
      if (wipe) begin
        for (int i = 0; i < NR; i++) begin
          start_d[i] = '0;
        end
        flags_d = '0;
        last_d  = '0;
      end else if (run) begin
        for (int i = 0; i < NR; i++) begin
          if (!entry_i.holds[i]) begin
            start_d[i] = '0;
          end else if (base_zero[i]) begin
            start_d[i] = entry_i.stamp;
          end
        end
        flags_d = rule_flags;
        last_d  = entry_i.stamp;
      end
      // mask rebuild
      mask      = {flags_d, entry_i.vendor};
      acked_new = acked_q & mask;
      acked_d   = acked_new;
      if ((mask & ~latched_q & ~acked_new) != '0) begin
        sound_d = 1'b1;
      end
      if (mask == '0) begin
        sound_d = 1'b0;
      end
      latched_d  = mask;
      silenced_d = (mask != '0) && ((mask & ~acked_new) == '0);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NR; i++) begin
        start_q[i] <= '0;
      end
      flags_q    <= '0;
      last_q     <= '0;
      latched_q  <= '0;
      acked_q    <= '0;
      sound_q    <= 1'b0;
      silenced_q <= 1'b0;
    end else if (pop_o) begin
      for (int i = 0; i < NR; i++) begin
        start_q[i] <= start_d[i];
      end
      flags_q    <= flags_d;
      last_q     <= last_d;
      latched_q  <= latched_d;
      acked_q    <= acked_d;
      sound_q    <= sound_d;
      silenced_q <= silenced_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      alarm_q    <= latched_d;
      unacked_q  <= (latched_d & ~acked_d) != '0;
      critical_q <= latched_d != '0;
      notice_q   <= entry_i.notice;
      offline_q  <= (latched_d != '0) && !entry_i.cloud_fresh;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign alarm_bits_o         = alarm_q;
  assign unacked_alarm_o      = unacked_q;
  assign critical_o           = critical_q;
  assign battery_notice_o     = notice_q;
  assign offline_last_known_o = offline_q;
  assign sound_request_o      = sound_q;
  assign muted_o              = silenced_q;

  // result consistency
  a_muted_has_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!muted_o || critical_o))
    else $error("muted without any alarm");

  a_muted_not_unacked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(muted_o && unacked_alarm_o))
    else $error("muted while an alarm is unacknowledged");

  a_sound_has_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!sound_request_o || critical_o))
    else $error("sound requested with an empty mask");

  a_offline_no_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && offline_last_known_o) |->
      (critical_o && battery_notice_o == svam_pkg::NOTICE_NONE))
    else $error("offline flag with battery notice or no alarm");

  a_ack_clears_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.req == svam_pkg::REQ_ACK) |=> !sound_q)
    else $error("sound still pending after acknowledge");

endmodule

@@ src/sustained_vital_alarm_manager_unit.sv @@
// Sustained vital alarm manager.
// Channels: an event channel (in_valid_i / in_stall_o) carrying one evaluate
// or acknowledge word, a result channel (out_valid_o / out_stall_i) giving
// one result word per event, and a configuration write channel
// (cfg_valid_i / cfg_ready_o, cfg_idx_i, cfg_data_i) that is always ready.
// Configuration must be written only while the block holds no pending event;
// the block itself does not enforce this. An event word is written into the
// front queue and is computed into the back end's result register as it
// leaves, where the result waits until taken. Throughput: one event per
// cycle while the receiver does not stall; every step is a handful of 32-bit
// subtract-and-compare operations in the back end, done combinationally.
// When the receiver stalls, the result register holds and the two-word
// queue absorbs further events; in_stall_o rises once the queue is full.
// Reset clears the rule timers, alarm masks, sound and mute state, the
// queue and the result valid, and loads the register defaults. No sweep
// is needed after reset.
// depends on svam_pkg, svam_front, svam_queue, svam_back
module sustained_vital_alarm_manager_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [svam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [svam_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic                              new_sample_i,
  input  logic                              vitals_fresh_i,
  input  logic                              cloud_fresh_i,
  input  logic [svam_pkg::STAMP_IN_W-1:0]   measured_time_i,
  input  logic [svam_pkg::OX_W-1:0]         oxygen_value_i,
  input  logic [svam_pkg::HR_W-1:0]         heart_value_i,
  input  logic [svam_pkg::VENDOR_W-1:0]     vendor_flags_i,
  input  logic                              battery_critical_i,
  input  logic                              battery_low_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [svam_pkg::MASK_W-1:0]       alarm_bits_o,
  output logic                              unacked_alarm_o,
  output logic                              critical_o,
  output logic [svam_pkg::NOTICE_W-1:0]     battery_notice_o,
  output logic                              offline_last_known_o,
  output logic                              sound_request_o,
  output logic                              muted_o
);

  svam_pkg::entry_t push_entry, pop_entry;
  svam_pkg::cfg_t   cfg;
  logic             push, pop, q_full, q_avail;

  // intake and classification
  svam_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .new_sample_i       (new_sample_i),
    .vitals_fresh_i     (vitals_fresh_i),
    .cloud_fresh_i      (cloud_fresh_i),
    .measured_time_i    (measured_time_i),
    .oxygen_value_i     (oxygen_value_i),
    .heart_value_i      (heart_value_i),
    .vendor_flags_i     (vendor_flags_i),
    .battery_critical_i (battery_critical_i),
    .battery_low_i      (battery_low_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .entry_o            (push_entry),
    .cfg_o              (cfg)
  );

  // decoupling queue
  svam_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .avail_o (q_avail),
    .entry_o (pop_entry)
  );

  // rule engine and result register
  svam_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .q_avail_i            (q_avail),
    .entry_i              (pop_entry),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .alarm_bits_o         (alarm_bits_o),
    .unacked_alarm_o      (unacked_alarm_o),
    .critical_o           (critical_o),
    .battery_notice_o     (battery_notice_o),
    .offline_last_known_o (offline_last_known_o),
    .sound_request_o      (sound_request_o),
    .muted_o              (muted_o)
  );

endmodule
